/* design/btpc_pkg.sv */
package btpc_pkg;

  localparam int unsigned RawW  = 20;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  // one bit of quotient per divider stage
  localparam int unsigned DivStages = 32;

  localparam logic [CfgIdxW-1:0] RegTempCalib  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressCalA  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressCalB  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressCalC  = 2'd3;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  // result fields carried alongside the datapath
  typedef struct packed {
    word_t temp_centi;
    word_t fine_temp;
  } temp_res_t;

  function automatic word_t sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic word_t asr(input word_t x, input int unsigned n);
    return word_t'($signed(x) >>> n);
  endfunction

endpackage

/* design/btpc_cfg_regs.sv */
module btpc_cfg_regs
  import btpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output calib_t              calib_o
);

  logic [47:0] temp_q;
  logic [63:0] pa_q, pb_q;
  logic [15:0] pc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTempCalib: temp_q <= cfg_data_i[47:0];
        RegPressCalA: pa_q   <= cfg_data_i;
        RegPressCalB: pb_q   <= cfg_data_i;
        RegPressCalC: pc_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign calib_o = '{t1: temp_q[15:0], t2: temp_q[31:16], t3: temp_q[47:32],
                     p1: pa_q[15:0], p2: pa_q[31:16], p3: pa_q[47:32], p4: pa_q[63:48],
                     p5: pb_q[15:0], p6: pb_q[31:16], p7: pb_q[47:32], p8: pb_q[63:48],
                     p9: pc_q};

endmodule

/* design/btpc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage; advances on en_i.
module btpc_divider
  import btpc_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  word_t            num_i,
  input  word_t            den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output word_t            quot_o,
  output logic [SideW-1:0] side_o
);

  logic                          v_q    [DivStages];
  word_t                         rem_q  [DivStages];
  word_t                         num_q  [DivStages];
  word_t                         den_q  [DivStages];
  logic [SideW-1:0]              side_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic             v_in;
    word_t            rem_in;
    word_t            num_in;
    word_t            den_in;
    logic [SideW-1:0] side_in;
    logic [WordW:0]   trial;
    logic [WordW:0]   diff;

    if (s == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, num_in[WordW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[WordW]) begin
          rem_q[s] <= diff[WordW-1:0];
          num_q[s] <= {num_in[WordW-2:0], 1'b1};
        end else begin
          rem_q[s] <= trial[WordW-1:0];
          num_q[s] <= {num_in[WordW-2:0], 1'b0};
        end
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[DivStages-1];
  assign quot_o  = num_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule

/* design/baro_temp_pressure_compensation_top.sv */
// Pipelined 32-bit integer barometric compensation. One raw temperature/pressure beat is
// accepted every cycle unless the output stalls; each beat passes the input register, 11 arithmetic
// stages, a 32-stage unsigned divider, 4 correction stages and the
// output register. The whole pipe stalls together when the output is not taken.
// The user must write calibration through the cfg port (index 0..3) only while idle; the block
// does not enforce this. A zero divisor gives press_pa 0 and press_valid 0.
module baro_temp_pressure_compensation_top
  import btpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [39:0]         s_axis_tdata_i,   // raw_temp[19:0], raw_press[39:20]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [95:0]         m_axis_tdata_o,   // temp_centi, fine_temp, press_pa
  output logic                m_axis_tuser_o,   // press_valid
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NS = 11;

  calib_t c;
  logic   en;

  btpc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .calib_o(c)
  );

  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // front pipeline registers; v_q[k] qualifies slot k-1
  logic [NS+1:1] v_q;
  word_t at_q[NS+1], ap_q[NS+1], fine_q[NS+1], tc_q[NS+1];
  word_t x1_q[NS+1], x2_q[NS+1], x3_q[NS+1], x4_q[NS+1];
  word_t pa_q[NS+1], pb_q[NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[NS:1], s_axis_tvalid_i};
  end

  // carry-through fields; each stage overrides what it computes below
  word_t n_x1[NS+1], n_x2[NS+1], n_x3[NS+1], n_x4[NS+1], n_fine[NS+1], n_tc[NS+1];
  word_t n_pa[NS+1], n_pb[NS+1];

  always_comb begin
    for (int s = 1; s <= NS; s++) begin
      n_x1[s] = x1_q[s-1]; n_x2[s] = x2_q[s-1]; n_x3[s] = x3_q[s-1];
      n_x4[s] = x4_q[s-1]; n_fine[s] = fine_q[s-1]; n_tc[s] = tc_q[s-1];
      n_pa[s] = pa_q[s-1]; n_pb[s] = pb_q[s-1];
    end
    // s1: temperature differences
    n_x1[1] = (at_q[0] >> 3) - ({16'd0, c.t1} << 1);
    n_x2[1] = (at_q[0] >> 4) - {16'd0, c.t1};
    // s2: products
    n_x1[2] = x1_q[1] * sx16(c.t2);
    n_x2[2] = x2_q[1] * x2_q[1];
    // s3
    n_x1[3] = asr(x1_q[2], 11);
    n_x2[3] = asr(x2_q[2], 12) * sx16(c.t3);
    // s4
    n_fine[4] = x1_q[3] + asr(x2_q[3], 14);
    // s5
    n_x1[5] = fine_q[4] * 32'd5 + 32'd128;
    n_pa[5] = asr(fine_q[4], 1) - 32'd64000;
    // s6
    n_tc[6] = asr(x1_q[5], 8);
    n_x1[6] = asr(pa_q[5], 2) * asr(pa_q[5], 2);   // sq
    n_x2[6] = pa_q[5] * sx16(c.p5);
    n_x3[6] = pa_q[5] * sx16(c.p2);
    // s7
    n_x4[7] = asr(x1_q[6], 11) * sx16(c.p6);
    n_x1[7] = sx16(c.p3) * asr(x1_q[6], 13);
    // s8
    n_pb[8] = asr(x4_q[7] + (x2_q[7] << 1), 2) + (sx16(c.p4) << 16);
    n_pa[8] = asr(asr(x1_q[7], 3) + asr(x3_q[7], 1), 18);
    // s9
    n_pa[9] = (32'd32768 + pa_q[8]) * {16'd0, c.p1};
    // s10
    n_pa[10] = asr(pa_q[9], 15);
    n_pb[10] = (32'd1048576 - ap_q[9]) - asr(pb_q[9], 12);
    // s11
    n_pb[11] = pb_q[10] * 32'd3125;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      at_q[0] <= {12'd0, s_axis_tdata_i[19:0]};
      ap_q[0] <= {12'd0, s_axis_tdata_i[39:20]};
      x1_q[0] <= '0; x2_q[0] <= '0; x3_q[0] <= '0; x4_q[0] <= '0;
      fine_q[0] <= '0; tc_q[0] <= '0; pa_q[0] <= '0; pb_q[0] <= '0;
      for (int s = 1; s <= NS; s++) begin
        at_q[s] <= at_q[s-1]; ap_q[s] <= ap_q[s-1];
        x1_q[s] <= n_x1[s]; x2_q[s] <= n_x2[s]; x3_q[s] <= n_x3[s]; x4_q[s] <= n_x4[s];
        fine_q[s] <= n_fine[s]; tc_q[s] <= n_tc[s]; pa_q[s] <= n_pa[s]; pb_q[s] <= n_pb[s];
      end
    end
  end

  // divide: numerator as pr<<1 or pr, post-scale x2 in the latter case
  word_t pr_in, num, den;
  logic  big, zero;
  assign pr_in = pb_q[NS];
  assign den   = pa_q[NS];
  assign big   = pr_in[31];
  assign zero  = (den == '0);
  assign num   = big ? pr_in : (pr_in << 1);

  localparam int unsigned SideW = 2 * WordW + 2;
  logic             dv;
  word_t            dq;
  logic [SideW-1:0] dside;

  btpc_divider #(.SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_q[NS+1]),
    .num_i(num), .den_i(zero ? 32'd1 : den),
    .side_i({tc_q[NS], fine_q[NS], big, zero}),
    .valid_o(dv), .quot_o(dq), .side_o(dside)
  );

  // post-division correction, 4 stages
  logic  pz_q[4];
  word_t ptc_q[4], pfn_q[4], pr_q[4];
  word_t pa2_q[1:2], pb2_q[1:2];
  logic  [3:0] pvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pvl_q <= '0;
    else if (en) pvl_q <= {pvl_q[2:0], dv};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // q0: final quotient
      pr_q[0]  <= dside[1] ? (dq << 1) : dq;
      ptc_q[0] <= dside[SideW-1 -: WordW];
      pfn_q[0] <= dside[2 +: WordW];
      pz_q[0]  <= dside[0];
      // q1: squares / products
      pr_q[1]  <= pr_q[0]; ptc_q[1] <= ptc_q[0]; pfn_q[1] <= pfn_q[0]; pz_q[1] <= pz_q[0];
      pa2_q[1] <= ((pr_q[0] >> 3) * (pr_q[0] >> 3)) >> 13;
      pb2_q[1] <= asr((pr_q[0] >> 2) * sx16(c.p8), 13);
      // q2
      pr_q[2]  <= pr_q[1]; ptc_q[2] <= ptc_q[1]; pfn_q[2] <= pfn_q[1]; pz_q[2] <= pz_q[1];
      pa2_q[2] <= asr(sx16(c.p9) * pa2_q[1], 12);
      pb2_q[2] <= pb2_q[1];
      // q3
      pr_q[3]  <= pz_q[2] ? '0 : pr_q[2] + asr(pa2_q[2] + pb2_q[2] + sx16(c.p7), 4);
      ptc_q[3] <= ptc_q[2]; pfn_q[3] <= pfn_q[2]; pz_q[3] <= pz_q[2];
    end
  end

  // output register
  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= pvl_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata_o <= {pr_q[3], pfn_q[3], ptc_q[3]};
      m_axis_tuser_o <= !pz_q[3];
    end
  end

  assign m_axis_tvalid_o = ov_q;

endmodule

/* sim/btpc_checker.sv */
`timescale 1ns / 1ps
module btpc_checker
  import btpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [39:0]         s_axis_tdata_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [95:0]         m_axis_tdata_i,
  input  logic                m_axis_tuser_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] press_pa;
    logic        press_valid;
  } comp_res_t;

  logic [47:0] temp_cal_q;
  logic [63:0] press_a_q, press_b_q;
  logic [15:0] press_c_q;
  comp_res_t   expected_q[$];

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sgn16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_res_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
    logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] x, y, d, fine, sq, pr;
    comp_res_t r;
    ut = {12'd0, raw_t};
    up = {12'd0, raw_p};
    t1 = {16'd0, temp_cal_q[15:0]};
    t2 = sgn16(temp_cal_q[31:16]);
    t3 = sgn16(temp_cal_q[47:32]);
    p1 = {16'd0, press_a_q[15:0]};
    p2 = sgn16(press_a_q[31:16]);
    p3 = sgn16(press_a_q[47:32]);
    p4 = sgn16(press_a_q[63:48]);
    p5 = sgn16(press_b_q[15:0]);
    p6 = sgn16(press_b_q[31:16]);
    p7 = sgn16(press_b_q[47:32]);
    p8 = sgn16(press_b_q[63:48]);
    p9 = sgn16(press_c_q);
    x = sra(((ut >> 3) - (t1 << 1)) * t2, 11);
    d = (ut >> 4) - t1;
    y = sra(sra(d * d, 12) * t3, 14);
    fine = x + y;
    r.fine_temp = fine;
    r.temp_centi = sra(fine * 32'd5 + 32'd128, 8);
    r.press_valid = 1'b1;
    x = sra(fine, 1) - 32'd64000;
    sq = sra(x, 2) * sra(x, 2);
    y = sra(sq, 11) * p6;
    y = y + ((x * p5) << 1);
    y = sra(y, 2) + (p4 << 16);
    x = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * x, 1), 18);
    x = sra((32'd32768 + x) * p1, 15);
    if (x == 32'd0) begin
      pr = 32'd0;
      r.press_valid = 1'b0;
    end else begin
      pr = ((32'd1048576 - up) - sra(y, 12)) * 32'd3125;
      if (pr < 32'h8000_0000) pr = (pr << 1) / x;
      else pr = (pr / x) * 32'd2;
      x = sra(p9 * (((pr >> 3) * (pr >> 3)) >> 13), 12);
      y = sra((pr >> 2) * p8, 13);
      pr = pr + sra(x + y + p7, 4);
    end
    r.press_pa = pr;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    comp_res_t got, want;
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q <= '0;
      press_b_q <= '0;
      press_c_q <= '0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      // predict with calibration as it stood before this edge
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_q.push_back(compensate(s_axis_tdata_i[19:0], s_axis_tdata_i[39:20]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[31:0], m_axis_tdata_i[63:32], m_axis_tdata_i[95:64],
               m_axis_tuser_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat tdata=%h tuser=%b", $time,
                   m_axis_tdata_i, m_axis_tuser_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected temp=%h fine=%h press=%h valid=%b", $time,
                     want.temp_centi, want.fine_temp, want.press_pa, want.press_valid);
            $display("%0t:          actual   temp=%h fine=%h press=%h valid=%b", $time,
                     got.temp_centi, got.fine_temp, got.press_pa, got.press_valid);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTempCalib: temp_cal_q <= cfg_data_i[47:0];
          RegPressCalA: press_a_q <= cfg_data_i;
          RegPressCalB: press_b_q <= cfg_data_i;
          RegPressCalC: press_c_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* sim/baro_temp_pressure_compensation_top_tb.sv */
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_top_tb;
  import btpc_pkg::*;

  localparam int Latency = 48;
  localparam int StallLimit = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [39:0]         s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [95:0]         m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  fail_count, pending, quiet_cycles;
  bit                  no_idle;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  baro_temp_pressure_compensation_top uut (.*);

  btpc_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= 12);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays up after the beat; the next call or drain() decides what follows
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_pair(input logic [19:0] rt, input logic [19:0] rp);
    cfg_valid_i <= 1'b0;
    if (!no_idle && $urandom_range(99) < 12) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {rp, rt};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic send_stream(input int n);
    repeat (n) send_pair(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
  endtask

  // real-sensor style calibration with small random spread
  task automatic load_typical();
    write_reg(RegTempCalib, {16'd0, 16'(-1000 + $urandom_range(20)), 16'(26000 + $urandom_range(200)),
                             16'(27000 + $urandom_range(400))});
    write_reg(RegPressCalA, {16'(2800 + $urandom_range(100)), 16'(24000 + $urandom_range(500)),
                             16'(-10600 + $urandom_range(100)), 16'(36000 + $urandom_range(2000))});
    write_reg(RegPressCalB, {16'(-12000 + $urandom_range(100)), 16'(15500 + $urandom_range(100)),
                             16'(-7) , 16'(140 + $urandom_range(20))});
    write_reg(RegPressCalC, 64'(6000 + $urandom_range(200)));
  endtask

  initial begin
    no_idle = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // all-zero calibration: divisor zero path
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    drain();
    load_typical();
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'd0, 20'hFFFFF);
    send_pair(20'hFFFFF, 20'd0);
    send_pair(20'd519888, 20'd415148);
    send_pair(20'h55555, 20'hAAAAA);
    send_pair(20'hAAAAA, 20'h55555);
    drain();
    // extremes of every coefficient
    write_reg(RegTempCalib, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegPressCalA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegPressCalB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegPressCalC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'h12345, 20'h80000);
    drain();
    write_reg(RegTempCalib, 64'h0000_8000_8000_FFFF);
    write_reg(RegPressCalA, 64'h8000_8000_8000_FFFF);
    write_reg(RegPressCalB, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(RegPressCalC, 64'h0000_0000_0000_8000);
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'h7FFFF, 20'h40000);
    drain();
    write_reg(RegTempCalib, 64'h0000_7FFF_7FFF_0001);
    write_reg(RegPressCalA, 64'h7FFF_7FFF_7FFF_0001);
    write_reg(RegPressCalB, 64'h8000_8000_8000_8000);
    write_reg(RegPressCalC, 64'h0000_0000_0000_7FFF);
    send_pair(20'd0, 20'hFFFFF);
    send_pair(20'hFFFFF, 20'd0);
    drain();
    // random phases
    load_typical();
    no_idle = 1'b1;
    send_stream(100);
    no_idle = 1'b0;
    send_stream(60);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegTempCalib, {$urandom, $urandom});
      write_reg(RegPressCalA, {$urandom, $urandom});
      write_reg(RegPressCalB, {$urandom, $urandom});
      write_reg(RegPressCalC, {$urandom, $urandom});
      send_stream(30);
      drain();
    end
    load_typical();
    send_stream(150);
    drain();
    repeat (Latency + 10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
